>>> design/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD       = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;

    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_62         = 6'd62;
    localparam logic [5:0] SYM_63         = 6'd63;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAR  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_OVER_CAP  = 2'd3
    } status_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       final_res;
        status_t    status;
        logic [15:0] bytes_written;
    } result_t;

endpackage

>>> design/base64url_stream_decoder.sv
// data path: an accepted input goes to the input reg, then the result reg
// throughput: one character per cycle unless m_tready stalls the output, one result
// per character, set by the combinational decode and accumulator update in between
// reset: synchronous active-low aresetn clears the valid flags of both stages, the
// decode state, and sets the capacity register to 65535
module base64url_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] bytes_written
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [0] byte_valid, [2:1] status
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    b64d_pkg::result_t out_reg;
    b64d_pkg::result_t result;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    b64d_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .character   (in_char_reg),
        .last        (in_last_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.bytes_written, out_reg.data_byte};
    assign m_tlast  = out_reg.final_res;
    assign m_tuser  = {out_reg.status, out_reg.byte_valid};

endmodule

>>> design/b64d_sym_dec.sv
module b64d_sym_dec (
    input  logic [7:0] character,
    output logic       sym_ok,
    output logic [5:0] sym_value
);

    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic [7:0] digit_off;

    assign upper_off = character - b64d_pkg::CHAR_UPPER_A;
    assign lower_off = character - b64d_pkg::CHAR_LOWER_A;
    assign digit_off = character - b64d_pkg::CHAR_DIGIT_0;

    always_comb begin
        sym_ok    = 1'b1;
        sym_value = '0;
        priority if (character >= b64d_pkg::CHAR_UPPER_A &&
                     character <= b64d_pkg::CHAR_UPPER_Z) begin
            sym_value = upper_off[5:0];
        end else if (character >= b64d_pkg::CHAR_LOWER_A &&
                     character <= b64d_pkg::CHAR_LOWER_Z) begin
            sym_value = lower_off[5:0] + b64d_pkg::SYM_LOWER_BASE;
        end else if (character >= b64d_pkg::CHAR_DIGIT_0 &&
                     character <= b64d_pkg::CHAR_DIGIT_9) begin
            sym_value = digit_off[5:0] + b64d_pkg::SYM_DIGIT_BASE;
        end else if (character == b64d_pkg::CHAR_MINUS ||
                     character == b64d_pkg::CHAR_PLUS) begin
            sym_value = b64d_pkg::SYM_62;
        end else if (character == b64d_pkg::CHAR_UNDERLINE ||
                     character == b64d_pkg::CHAR_SLASH) begin
            sym_value = b64d_pkg::SYM_63;
        end else begin
            sym_ok = 1'b0;
        end
    end

endmodule

>>> design/b64d_core.sv
module b64d_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                step_en,
    input  logic [7:0]          character,
    input  logic                last,
    output b64d_pkg::result_t   result
);

    logic [15:0]       capacity_reg;
    logic [11:0]       acc_reg, acc_next;
    logic [2:0]        pend_reg, pend_next;
    logic              pad_reg, pad_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       count_reg, count_next;
    b64d_pkg::status_t err_reg, err_next;

    logic       sym_ok;
    logic [5:0] sym_value;
    logic [3:0] total;
    logic [3:0] rem_bits;
    logic [11:0] shifted;

    b64d_sym_dec u_sym_dec (
        .character (character),
        .sym_ok    (sym_ok),
        .sym_value (sym_value)
    );

    always_comb begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        pad_next   = pad_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        err_next   = err_reg;
        total      = {1'b0, pend_reg} + 4'd6;
        rem_bits   = total - 4'd8;
        shifted    = '0;

        result.byte_valid = 1'b0;
        result.data_byte  = '0;

        if (err_reg == b64d_pkg::ST_OK) begin
            if (character == b64d_pkg::CHAR_PAD) begin
                pad_next = 1'b1;
            end else if (pad_reg || !sym_ok) begin
                err_next = b64d_pkg::ST_BAD_CHAR;
            end else begin
                acc_next   = {acc_reg[5:0], sym_value};
                phase_next = phase_reg + 2'd1;
                pend_next  = total[2:0];
                if (total >= 4'd8) begin
                    pend_next = rem_bits[2:0];
                    if (count_reg >= capacity_reg) begin
                        err_next = b64d_pkg::ST_OVER_CAP;
                    end else begin
                        // at most four bits stay pending below the byte
                        shifted           = acc_next >> rem_bits;
                        result.byte_valid = 1'b1;
                        result.data_byte  = shifted[7:0];
                        count_next        = count_reg + 16'd1;
                    end
                end
            end
        end

        if (last && err_next == b64d_pkg::ST_OK && phase_next == 2'd1) begin
            err_next = b64d_pkg::ST_BAD_LEN;
        end

        result.final_res     = last;
        result.status        = err_next;
        result.bytes_written = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= b64d_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            pend_reg  <= '0;
            pad_reg   <= 1'b0;
            phase_reg <= '0;
            count_reg <= '0;
            err_reg   <= b64d_pkg::ST_OK;
        end else if (step_en) begin
            if (last) begin
                // text ends here, next item starts fresh
                acc_reg   <= '0;
                pend_reg  <= '0;
                pad_reg   <= 1'b0;
                phase_reg <= '0;
                count_reg <= '0;
                err_reg   <= b64d_pkg::ST_OK;
            end else begin
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                pad_reg   <= pad_next;
                phase_reg <= phase_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule
